// ----- rtl/core/stf_pkg.sv -----
// stf_pkg: request and response word types, function and status codes
// for the subscriber table fan-out block.
// No dependencies; used by every file under rtl/core.
package stf_pkg;

    localparam int unsigned ID_W    = 22;
    localparam int unsigned COUNT_W = 7;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_JOIN      = 2'd0,
        FUNC_BROADCAST = 2'd1,
        FUNC_LEAVE     = 2'd2,
        FUNC_NOP       = 2'd3
    } func_t;

    // response status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_UNUSED  = 2'd3
    } status_t;

    typedef struct packed {
        func_t             func;
        logic [ID_W-1:0]   sender_id;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]    dest_id;
        logic               dest_valid;
        status_t            status;
        logic [COUNT_W-1:0] member_count;
        logic               last;
    } rsp_t;

endpackage

// ----- rtl/core/stf_cell.sv -----
// stf_cell: one slot of the member table ring. Holds one identifier,
// loads it from its neighbour on a shift or from the write port.
// Depends on stf_pkg.
module stf_cell (
    input  logic                      clk,
    input  logic                      shift_en,
    input  logic [stf_pkg::ID_W-1:0]  shift_in,
    input  logic                      wr_en,
    input  logic [stf_pkg::ID_W-1:0]  wr_data,
    output logic [stf_pkg::ID_W-1:0]  value
);

    logic [stf_pkg::ID_W-1:0] value_reg;
    logic [stf_pkg::ID_W-1:0] value_next;

    // write port wins; the controller never asks for both
    always_comb
    begin
        value_next = value_reg;
        if (wr_en)
        begin
            value_next = wr_data;
        end
        else if (shift_en)
        begin
            value_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/core/subscriber_table_fanout.sv -----
// subscriber_table_fanout: top level. Ring of stf_cell slots plus the
// request sequencer and the response register. Depends on stf_pkg, stf_cell.
//
//   channel   | ports                    | flow
//   ----------+--------------------------+-----------------------------------
//   request   | start, busy, req         | word taken when start & !busy
//   response  | rsp_strobe, rsp          | one word per strobe cycle, no stall
//
// Join and func 3 complete on acceptance; the join response shows the next
// cycle. Broadcast and leave: a rotation through all slots, one slot past
// the head cell each step, then a finishing state; busy until that state
// ends. Copies go out as the next recipient is seen, the last one the cycle
// after finishing. The receiver cannot stall.
// Reset clears the count; slots need no reset.
module subscriber_table_fanout #(
    parameter int unsigned MAX_MEMBERS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  stf_pkg::req_t req,
    output logic          rsp_strobe,
    output stf_pkg::rsp_t rsp
);

    localparam int unsigned IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_MEMBERS - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_MEMBERS);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    stf_pkg::func_t           func_reg, func_next;
    logic [stf_pkg::ID_W-1:0] sender_reg, sender_next;
    logic [stf_pkg::ID_W-1:0] pend_reg, pend_next;
    logic                     have_reg, have_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [stf_pkg::ID_W-1:0] last_val_reg, last_val_next;
    logic                     strobe_reg, strobe_next;
    stf_pkg::rsp_t            rsp_reg, rsp_next;

    logic                     shift_en;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic [stf_pkg::ID_W-1:0] wr_data;
    logic [stf_pkg::ID_W-1:0] slot [MAX_MEMBERS];
    logic [stf_pkg::ID_W-1:0] head;
    logic                     step_live;

    // ring of slots; slot 0 is the head seen by the sequencer
    for (genvar i = 0; i < MAX_MEMBERS; i++)
    begin : g_cell
        stf_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .shift_in (slot[(i + 1) % MAX_MEMBERS]),
            .wr_en    (wr_en && (wr_idx == IDX_W'(i))),
            .wr_data  (wr_data),
            .value    (slot[i])
        );
    end

    assign head      = slot[0];
    assign step_live = CNT_W'(step_reg) < count_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        func_next     = func_reg;
        sender_next   = sender_reg;
        pend_next     = pend_reg;
        have_next     = have_reg;
        found_next    = found_reg;
        idx_next      = idx_reg;
        last_val_next = last_val_reg;
        strobe_next   = 1'b0;
        rsp_next      = rsp_reg;
        shift_en      = 1'b0;
        wr_en         = 1'b0;
        wr_idx        = idx_reg;
        wr_data       = last_val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next   = req.func;
                    sender_next = req.sender_id;
                    step_next   = '0;
                    have_next   = 1'b0;
                    found_next  = 1'b0;
                    case (req.func) inside
                        stf_pkg::FUNC_JOIN:
                        begin
                            rsp_next.dest_id    = '0;
                            rsp_next.dest_valid = 1'b0;
                            rsp_next.last       = 1'b1;
                            strobe_next         = 1'b1;
                            if (count_reg >= FULL_COUNT)
                            begin
                                rsp_next.status       = stf_pkg::STATUS_FULL;
                                rsp_next.member_count = stf_pkg::COUNT_W'(count_reg);
                            end
                            else
                            begin
                                // append at the tail
                                wr_en      = 1'b1;
                                wr_idx     = count_reg[IDX_W-1:0];
                                wr_data    = req.sender_id;
                                count_next = count_reg + 1'b1;
                                rsp_next.status       = stf_pkg::STATUS_OK;
                                rsp_next.member_count =
                                    stf_pkg::COUNT_W'(count_reg + 1'b1);
                            end
                        end
                        stf_pkg::FUNC_BROADCAST,
                        stf_pkg::FUNC_LEAVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                shift_en  = 1'b1;
                step_next = step_reg + 1'b1;
                if (func_reg == stf_pkg::FUNC_BROADCAST)
                begin
                    // hold one recipient back so the final one can carry last
                    if (step_live && (head != sender_reg))
                    begin
                        if (have_reg)
                        begin
                            strobe_next           = 1'b1;
                            rsp_next.dest_id      = pend_reg;
                            rsp_next.dest_valid   = 1'b1;
                            rsp_next.status       = stf_pkg::STATUS_OK;
                            rsp_next.member_count = stf_pkg::COUNT_W'(count_reg);
                            rsp_next.last         = 1'b0;
                        end
                        pend_next = head;
                        have_next = 1'b1;
                    end
                end
                else
                begin
                    // leave: first match and the tail value
                    if (step_live && (head == sender_reg) && !found_reg)
                    begin
                        found_next = 1'b1;
                        idx_next   = step_reg;
                    end
                    if (CNT_W'(step_reg) + 1'b1 == count_reg)
                    begin
                        last_val_next = head;
                    end
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                state_next            = ST_IDLE;
                strobe_next           = 1'b1;
                rsp_next.last         = 1'b1;
                rsp_next.status       = stf_pkg::STATUS_OK;
                rsp_next.dest_id      = '0;
                rsp_next.dest_valid   = 1'b0;
                rsp_next.member_count = stf_pkg::COUNT_W'(count_reg);
                if (func_reg == stf_pkg::FUNC_BROADCAST)
                begin
                    if (have_reg)
                    begin
                        rsp_next.dest_id    = pend_reg;
                        rsp_next.dest_valid = 1'b1;
                    end
                end
                else if (found_reg)
                begin
                    // tail moves into the freed slot
                    wr_en      = 1'b1;
                    wr_idx     = idx_reg;
                    wr_data    = last_val_reg;
                    count_next = count_reg - 1'b1;
                    rsp_next.member_count = stf_pkg::COUNT_W'(count_reg - 1'b1);
                end
                else
                begin
                    rsp_next.status = stf_pkg::STATUS_MISSING;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            have_reg   <= 1'b0;
            found_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            have_reg   <= have_next;
            found_reg  <= found_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        sender_reg   <= sender_next;
        pend_reg     <= pend_next;
        idx_reg      <= idx_next;
        last_val_reg <= last_val_next;
        rsp_reg      <= rsp_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign rsp_strobe = strobe_reg;
    assign rsp        = rsp_reg;

endmodule
